>>> rtl/huf_pkg.sv
// shared types and constants for the table-driven huffman decoder
package huf_pkg;

  localparam int TABLE_ENTRIES    = 256;
  localparam int LOOKAHEAD_BITS   = 16;
  localparam int IDX_W            = $clog2(TABLE_ENTRIES);
  localparam int CODE_W           = 16;
  localparam int LEN_W            = 5;
  localparam int SYM_W            = 8;
  localparam int ENTRY_W          = CODE_W + LEN_W + SYM_W;
  localparam int BUF_W            = 32;
  localparam int CNT_W            = 6;
  localparam int DECODE_THRESHOLD = 24;
  localparam int MAX_RESULTS      = 8;
  localparam int NRES_W           = $clog2(MAX_RESULTS);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BYTE,
    OP_DRAIN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic [7:0]        data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RD,
    ST_CMP,
    ST_FRD,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/huffman_table_decoder.sv
// Huffman decoder fed by a loaded, code-sorted table of 256 entries. A load
// item writes one table entry; a compressed byte releases up to eight symbols,
// each found by an eight-step binary search over the single-port table memory,
// each step a registered read and a compare, then one read of the hit entry.
// A drain item first pads with up to three zero bytes, then gives its one symbol.
// A four-entry command queue lets items be taken while the engine is busy,
// and the output register lets decoding continue while a symbol waits.
module huffman_table_decoder import huf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  entry_index,
  input  logic [15:0] entry_code,
  input  logic [4:0]  entry_length,
  input  logic [7:0]  entry_symbol,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  symbol,
  output logic        last
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  huf_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .entry_index  (entry_index),
    .entry_code   (entry_code),
    .entry_length (entry_length),
    .entry_symbol (entry_symbol),
    .data_byte    (data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  huf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  huf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .last       (last)
  );

endmodule

>>> rtl/huf_front.sv
// input side: classifies items and hands commands to the queue
module huf_front import huf_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  entry_index,
  input  logic [15:0] entry_code,
  input  logic [4:0]  entry_length,
  input  logic [7:0]  entry_symbol,
  input  logic [7:0]  data_byte,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic keep;
  logic idx_ok;

  assign idx_ok = {1'b0, entry_index} < 9'(TABLE_ENTRIES);

  always_comb begin
    q_cmd.idx  = entry_index[IDX_W-1:0];
    q_cmd.code = entry_code;
    q_cmd.len  = entry_length;
    q_cmd.sym  = entry_symbol;
    q_cmd.data = data_byte;
    unique case (kind)
      KIND_LOAD: begin
        q_cmd.op = OP_LOAD;
        keep     = idx_ok;
      end
      KIND_BYTE: begin
        q_cmd.op = OP_BYTE;
        keep     = 1'b1;
      end
      KIND_DRAIN: begin
        q_cmd.op = OP_DRAIN;
        keep     = 1'b1;
      end
      default: begin
        // unknown kind is taken and dropped
        q_cmd.op = OP_LOAD;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

>>> rtl/huf_queue.sv
// short command queue between front and back
module huf_queue import huf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full       = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/huf_back.sv
// decode engine: code table, bit buffer, binary search and output register
module huf_back import huf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] symbol,
  output logic       last
);

  logic [ENTRY_W-1:0] table_mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rdata;

  state_t              state, state_next;
  logic [IDX_W-1:0]    lo, lo_next;
  logic [IDX_W-1:0]    hi, hi_next;
  logic [BUF_W-1:0]    bit_buf, bit_buf_next;
  logic [CNT_W-1:0]    bit_cnt, bit_cnt_next;
  logic [NRES_W-1:0]   nres, nres_next;
  logic                drain, drain_next;
  logic                out_valid_next;
  logic [7:0]          symbol_next;
  logic                last_next;

  logic                mem_we;
  logic                mem_re;
  logic [IDX_W-1:0]    rd_addr;

  logic [IDX_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic [BUF_W-1:0]    app_buf;
  logic [CNT_W-1:0]    app_cnt;
  logic [BUF_W-1:0]    shifted;
  logic [LOOKAHEAD_BITS-1:0] target;
  logic [LOOKAHEAD_BITS-1:0] tab_code;
  logic [LEN_W-1:0]    raw_len;
  logic [CNT_W-1:0]    use_len;
  logic [CNT_W-1:0]    cnt_after;
  logic [BUF_W:0]      keep_mask;
  logic                out_free;
  logic                final_sym;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi} + 1'b1;
  assign mid      = mid_sum[IDX_W:1];
  assign app_buf  = {bit_buf[BUF_W-9:0], head.data};
  assign app_cnt  = bit_cnt + CNT_W'(8);

  // top lookahead bits of what the buffer holds
  assign shifted  = bit_buf >> (bit_cnt - CNT_W'(LOOKAHEAD_BITS));
  assign target   = shifted[LOOKAHEAD_BITS-1:0];
  assign tab_code = rdata[ENTRY_W-1 -: LOOKAHEAD_BITS];

  assign raw_len  = rdata[SYM_W +: LEN_W];
  always_comb begin
    if (raw_len == '0) begin
      use_len = CNT_W'(1);
    end else if ({1'b0, raw_len} > (LEN_W+1)'(LOOKAHEAD_BITS)) begin
      use_len = CNT_W'(LOOKAHEAD_BITS);
    end else begin
      use_len = CNT_W'(raw_len);
    end
  end

  assign cnt_after = bit_cnt - use_len;
  assign keep_mask = ((BUF_W+1)'(1) << cnt_after) - 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign final_sym = drain || (nres == NRES_W'(MAX_RESULTS-1))
                   || (cnt_after < CNT_W'(DECODE_THRESHOLD));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[head.idx] <= {head.code, head.len, head.sym};
    end
    if (mem_re) begin
      rdata <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_buf   <= '0;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_buf   <= bit_buf_next;
      bit_cnt   <= bit_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    nres   <= nres_next;
    drain  <= drain_next;
    symbol <= symbol_next;
    last   <= last_next;
  end

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    bit_buf_next   = bit_buf;
    bit_cnt_next   = bit_cnt;
    nres_next      = nres;
    drain_next     = drain;
    out_valid_next = out_valid && out_stall;
    symbol_next    = symbol;
    last_next      = last;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    rd_addr        = mid;

    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.op)
            OP_LOAD: begin
              mem_we = 1'b1;
            end
            OP_BYTE: begin
              drain_next = 1'b0;
              nres_next  = '0;
              lo_next    = '0;
              hi_next    = IDX_W'(TABLE_ENTRIES-1);
              if (bit_cnt <= CNT_W'(DECODE_THRESHOLD)) begin
                bit_buf_next = app_buf;
                bit_cnt_next = app_cnt;
                if (app_cnt >= CNT_W'(DECODE_THRESHOLD)) state_next = ST_RD;
              end else begin
                // buffer too full: byte dropped, decoding goes on
                state_next = ST_RD;
              end
            end
            OP_DRAIN: begin
              drain_next = 1'b1;
              nres_next  = '0;
              state_next = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        if (bit_cnt < CNT_W'(DECODE_THRESHOLD)) begin
          bit_buf_next = {bit_buf[BUF_W-9:0], 8'h00};
          bit_cnt_next = app_cnt;
        end else begin
          lo_next    = '0;
          hi_next    = IDX_W'(TABLE_ENTRIES-1);
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        mem_re     = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (tab_code > target) begin
          hi_next = mid - 1'b1;
          state_next = (mid - 1'b1 > lo) ? ST_RD : ST_FRD;
        end else begin
          lo_next = mid;
          state_next = (hi > mid) ? ST_RD : ST_FRD;
        end
      end
      ST_FRD: begin
        mem_re     = 1'b1;
        rd_addr    = lo;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          symbol_next    = rdata[SYM_W-1:0];
          last_next      = final_sym;
          bit_cnt_next   = cnt_after;
          bit_buf_next   = bit_buf & keep_mask[BUF_W-1:0];
          nres_next      = nres + 1'b1;
          lo_next        = '0;
          hi_next        = IDX_W'(TABLE_ENTRIES-1);
          state_next     = final_sym ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the table-driven huffman decoder
`timescale 1ns / 100ps

module tb_top import huf_pkg::*; ();

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  typedef enum {TBL_BYTEWISE, TBL_CANONICAL, TBL_SPARSE} tbl_shape_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_LOAD;
  logic [7:0]  entry_index = '0;
  logic [15:0] entry_code = '0;
  logic [4:0]  entry_length = '0;
  logic [7:0]  entry_symbol = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  symbol;
  logic        last;

  // decoder state as the testbench sees it
  logic [15:0] tbl_code [TABLE_ENTRIES];
  logic [4:0]  tbl_len [TABLE_ENTRIES];
  logic [7:0]  tbl_sym [TABLE_ENTRIES];
  logic [31:0] bit_buf = '0;
  int          bit_cnt = 0;

  decoded_t expected_syms[$];
  int       mismatches = 0;
  int       cycle_cnt = 0;
  bit       idle_en = 1'b1;
  int       hold_asked = 0;
  int       hold_taken = 0;
  int       hold_left = 0;

  huffman_table_decoder u_dut (
    .clk, .rst, .in_valid, .in_stall, .kind, .entry_index, .entry_code,
    .entry_length, .entry_symbol, .data_byte, .out_valid, .out_stall, .symbol, .last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // greatest entry whose code is not above the lookahead, then consume its length
  function automatic logic [7:0] decode_next();
    logic [31:0] shifted;
    logic [15:0] target;
    int lo, hi, mid, take;
    shifted = bit_buf >> (bit_cnt - LOOKAHEAD_BITS);
    target = shifted[15:0];
    lo = 0;
    hi = TABLE_ENTRIES - 1;
    while (hi > lo) begin
      mid = (lo + hi + 1) / 2;
      if ((tbl_code[mid] >> (CODE_W - LOOKAHEAD_BITS)) > target)
        hi = mid - 1;
      else
        lo = mid;
    end
    take = int'(tbl_len[lo]);
    if (take < 1) take = 1;
    if (take > LOOKAHEAD_BITS) take = LOOKAHEAD_BITS;
    bit_cnt -= take;
    if (bit_cnt < 32) bit_buf = bit_buf & ((32'd1 << bit_cnt) - 32'd1);
    return tbl_sym[lo];
  endfunction

  function automatic void predict_symbols(input logic [1:0] k, input logic [7:0] idx,
                                          input logic [15:0] code, input logic [4:0] len,
                                          input logic [7:0] sym, input logic [7:0] data);
    logic [7:0] got[$];
    decoded_t d;
    case (k)
      KIND_LOAD: begin
        tbl_code[idx] = code;
        tbl_len[idx] = len;
        tbl_sym[idx] = sym;
      end
      KIND_BYTE: begin
        // a byte arriving with more than 24 bits held is dropped
        if (bit_cnt <= DECODE_THRESHOLD) begin
          bit_buf = {bit_buf[23:0], data};
          bit_cnt += 8;
        end
        while (bit_cnt >= DECODE_THRESHOLD && got.size() < MAX_RESULTS)
          got.push_back(decode_next());
      end
      KIND_DRAIN: begin
        while (bit_cnt < DECODE_THRESHOLD) begin
          bit_buf = {bit_buf[23:0], 8'h00};
          bit_cnt += 8;
        end
        got.push_back(decode_next());
      end
      default: ;
    endcase
    for (int i = 0; i < got.size(); i++) begin
      d.sym = got[i];
      d.last = (i == got.size() - 1);
      expected_syms.push_back(d);
    end
  endfunction

  task automatic send_item(input logic [1:0] k, input logic [7:0] idx, input logic [15:0] code,
                           input logic [4:0] len, input logic [7:0] sym, input logic [7:0] data);
    while (idle_en && $urandom_range(99, 0) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    entry_index <= idx;
    entry_code <= code;
    entry_length <= len;
    entry_symbol <= sym;
    data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_symbols(k, idx, code, len, sym, data);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [15:0] code,
                            input logic [4:0] len, input logic [7:0] sym);
    send_item(KIND_LOAD, idx, code, len, sym, 8'($urandom_range(255, 0)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(KIND_BYTE, 8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)),
              5'($urandom_range(16, 0)), 8'($urandom_range(255, 0)), b);
  endtask

  task automatic send_drain();
    send_item(KIND_DRAIN, 8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)),
              5'($urandom_range(16, 0)), 8'($urandom_range(255, 0)),
              8'($urandom_range(255, 0)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_syms.size() != 0) @(posedge clk);
  endtask

  task automatic fill_table(input tbl_shape_t shape);
    logic [15:0] codes [TABLE_ENTRIES];
    logic [4:0]  lens [TABLE_ENTRIES];
    int used, width;
    used = 0;
    width = $urandom_range(4, 2);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      case (shape)
        TBL_BYTEWISE: begin
          codes[i] = 16'(i << 8);
          lens[i] = 5'd8;
        end
        TBL_SPARSE: begin
          // lowest code well above zero, so small lookaheads fall below every code
          codes[i] = 16'(16'h1000 + i * 240 + $urandom_range(239, 0));
          lens[i] = 5'($urandom_range(16, 0));
        end
        default: begin
          // canonical prefix code: lengths never shrink and the rest must still fit
          if (width < LOOKAHEAD_BITS && $urandom_range(3, 0) == 0) width++;
          while ((1 << (CODE_W - width)) + (TABLE_ENTRIES - 1 - i) > (1 << CODE_W) - used)
            width++;
          codes[i] = used[15:0];
          lens[i] = width[4:0];
          used += 1 << (CODE_W - width);
        end
      endcase
    end
    for (int i = 0; i < TABLE_ENTRIES; i++)
      load_entry(i[7:0], codes[i], lens[i], 8'($urandom_range(255, 0)));
  endtask

  task automatic send_random_items(input int n);
    int pick, at;
    logic [15:0] lo, hi;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        send_byte(8'($urandom_range(255, 0)));
      end else if (pick < 90) begin
        send_drain();
      end else begin
        // retune one entry without breaking the code order
        at = $urandom_range(TABLE_ENTRIES - 1, 0);
        lo = (at == 0) ? 16'h0000 : tbl_code[at - 1];
        hi = (at == TABLE_ENTRIES - 1) ? 16'hFFFF : tbl_code[at + 1];
        load_entry(at[7:0], 16'($urandom_range(hi, lo)), 5'($urandom_range(16, 0)),
                   8'($urandom_range(255, 0)));
      end
    end
  endtask

  task automatic test_corner_cases();
    fill_table(TBL_CANONICAL);
    // entry 0 raised to the code of entry 1, so small lookaheads fall below every code
    load_entry(8'd0, tbl_code[1], 5'd7, 8'h00);
    load_entry(8'd255, 16'hFFFF, 5'd16, 8'hFF);
    // zeros sit below every code, so entry 0 decodes them
    repeat (3) send_byte(8'h00);
    load_entry(8'd0, tbl_code[0], 5'd0, 8'h00);
    // zero length still takes one bit; drain pads 17 bits up to 25
    send_drain();
    // 32 bits held: eight symbols, bits left over for the next byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    // lookahead of all ones lands on the last entry
    send_drain();
    send_drain();
    send_drain();
    // more than 24 bits held, byte dropped
    send_byte(8'hA5);
    load_entry(8'd0, 16'h0000, 5'd16, 8'h3C);
    send_byte(8'h5A);
    wait_drained();
  endtask

  task automatic test_canonical_stream();
    send_random_items(25);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    send_random_items(25);
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_asked++;
    repeat (20) send_byte(8'($urandom_range(255, 0)));
    wait_drained();
  endtask

  // receiver side: random stalls, plus a long hold when one is asked for
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99, 0) < 21);
    end
  end

  always @(posedge clk) begin : check_symbols
    decoded_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_syms.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual symbol %02h last %b",
                 $time, symbol, last);
        mismatches++;
      end else begin
        want = expected_syms.pop_front();
        if (symbol !== want.sym) begin
          $display("%0t: symbol mismatch, expected %02h, actual %02h",
                   $time, want.sym, symbol);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout", $time);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_canonical_stream();
    test_no_idle();
    test_backpressure();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> huffman_table_decoder.f
rtl/huf_pkg.sv
rtl/huf_front.sv
rtl/huf_queue.sv
rtl/huf_back.sv
rtl/huffman_table_decoder.sv
tb/tb_top.sv
